[rtl/core/pdsl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdsl_pkg - shared types and constants for the PID drive controller
// Field widths, configuration codes, drive modes and the per-word control tag.
// ----------------------------------------------------------------------------
package pdsl_pkg;

  // Parameter defaults
  localparam int POSITION_WIDTH_DEF     = 32;
  localparam int GAIN_FRACTION_BITS_DEF = 16;
  localparam int INTEGRAL_WIDTH_DEF     = 48;

  // Fixed field widths
  localparam int FIELD_W    = 32;
  localparam int VEL_W      = 16;
  localparam int POWER_W    = 16;
  localparam int POWER_FRAC = 15;
  localparam int GAIN_W     = 32;
  localparam int SLEW_W     = 16;
  localparam int BAND_W     = 31;
  localparam int SPEED_W    = 15;

  // Product datapath
  localparam int MAG_W  = 64;  // operand magnitude, split in two halves
  localparam int HALF_W = 32;
  localparam int PROD_W = 64;  // one partial product
  localparam int TERM_W = 61;  // saturated term magnitude, up to 2^60
  localparam int SUM_W  = 64;  // signed sum of three terms

  // Stream and configuration ports
  localparam int S_TDATA_W   = 136;
  localparam int M_TDATA_W   = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_SLEW_STEP   = 3'd3,
    CFG_SETTLE_BAND = 3'd4,
    CFG_SPEED_LIMIT = 3'd5,
    CFG_GOAL        = 3'd6,
    CFG_MODE        = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_DRIVE = 2'd0,
    MODE_TURN  = 2'd1,
    MODE_SWING = 2'd2,
    MODE_HALT  = 2'd3
  } mode_t;

  // What the output stage does with a word
  typedef enum logic [1:0] {
    KIND_PID  = 2'd0,
    KIND_HALT = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic  restart;
    kind_t kind;
  } ctl_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic        [SLEW_W-1:0]  slew_step;
    logic        [BAND_W-1:0]  settle_band;
    logic        [SPEED_W-1:0] speed_limit;
    logic signed [FIELD_W-1:0] goal;
    mode_t                     mode;
  } cfg_t;

endpackage
`default_nettype wire

[rtl/core/pdsl_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdsl_front - input register, measured position and error
// Picks the wheel average or the heading, forms the saturated error and the
// settle check against band and speed limit.
// ----------------------------------------------------------------------------
module pdsl_front import pdsl_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        en_a,
  input  wire logic                        en_b,
  input  wire logic                        en_c,
  input  wire cfg_t                        cfg,
  input  wire logic                        restart,
  input  wire logic signed [FIELD_W-1:0]   left_position,
  input  wire logic signed [FIELD_W-1:0]   right_position,
  input  wire logic signed [FIELD_W-1:0]   heading,
  input  wire logic signed [VEL_W-1:0]     left_velocity,
  input  wire logic signed [VEL_W-1:0]     right_velocity,
  output logic                             restart_c,
  output logic signed [POSITION_WIDTH-1:0] err_c,
  output logic                             near_c
);

  localparam int PW = POSITION_WIDTH;
  localparam int DW = ((PW > FIELD_W) ? PW : FIELD_W) + 1;
  localparam int NW = ((PW > BAND_W) ? PW : BAND_W) + 1;
  localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

  // Stage A: input register
  logic                      a_restart;
  logic signed [FIELD_W-1:0] a_lpos, a_rpos, a_head;
  logic signed [VEL_W-1:0]   a_lvel, a_rvel;

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_restart <= restart;
      a_lpos    <= left_position;
      a_rpos    <= right_position;
      a_head    <= heading;
      a_lvel    <= left_velocity;
      a_rvel    <= right_velocity;
    end
  end

  // Take the low bits when narrower, zero-extend when wider
  logic signed [PW-1:0] lp_w, rp_w, hd_w;
  if (PW <= FIELD_W) begin : g_narrow
    assign lp_w = a_lpos[PW-1:0];
    assign rp_w = a_rpos[PW-1:0];
    assign hd_w = a_head[PW-1:0];
  end else begin : g_wide
    assign lp_w = {{(PW-FIELD_W){1'b0}}, a_lpos};
    assign rp_w = {{(PW-FIELD_W){1'b0}}, a_rpos};
    assign hd_w = {{(PW-FIELD_W){1'b0}}, a_head};
  end

  logic signed [PW:0]    pair_sum;
  logic signed [VEL_W:0] lim_pos, lim_neg, lv_x, rv_x;
  logic                  vel_ok;

  assign pair_sum = (PW+1)'(lp_w) + (PW+1)'(rp_w);
  assign lim_pos  = $signed({2'b00, cfg.speed_limit});
  assign lim_neg  = -lim_pos;
  assign lv_x     = (VEL_W+1)'(a_lvel);
  assign rv_x     = (VEL_W+1)'(a_rvel);
  // A velocity of full negative scale never passes
  assign vel_ok   = (lv_x <= lim_pos) && (lv_x >= lim_neg) &&
                    (rv_x <= lim_pos) && (rv_x >= lim_neg);

  // Stage B: position
  logic                 b_restart;
  logic signed [PW-1:0] b_pos;
  logic                 b_vel_ok;

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_restart <= a_restart;
      // dropping the low bit of the sum floors the average
      b_pos     <= (cfg.mode == MODE_DRIVE) ? pair_sum[PW:1] : hd_w;
      b_vel_ok  <= vel_ok;
    end
  end

  logic signed [DW-1:0] diff;
  logic                 ovf;
  logic signed [PW-1:0] err;
  logic signed [NW-1:0] err_x, band_pos, band_neg;

  assign diff     = DW'(cfg.goal) - DW'(b_pos);
  assign ovf      = (diff[DW-1:PW-1] != '0) && (diff[DW-1:PW-1] != '1);
  assign err      = ovf ? (diff[DW-1] ? PMIN : PMAX) : diff[PW-1:0];
  assign err_x    = NW'(err);
  assign band_pos = $signed(NW'(cfg.settle_band));
  assign band_neg = -band_pos;

  // Stage C: error and settle check
  always_ff @(posedge clk) begin
    if (en_c) begin
      restart_c <= b_restart;
      err_c     <= err;
      near_c    <= (err_x <= band_pos) && (err_x >= band_neg) && b_vel_ok;
    end
  end

endmodule
`default_nettype wire

[rtl/core/pdsl_state.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdsl_state - loop state and tick classification
// Holds the integral, last error and finished flag; classifies each tick.
// ----------------------------------------------------------------------------
module pdsl_state import pdsl_pkg::*; #(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en_d,
  input  wire logic                        take,
  input  wire mode_t                       mode,
  input  wire logic                        restart_c,
  input  wire logic signed [POSITION_WIDTH-1:0] err_c,
  input  wire logic                        near_c,
  output ctl_t                             ctl_d,
  output logic signed [POSITION_WIDTH-1:0] err_d,
  output logic signed [INTEGRAL_WIDTH-1:0] esum_d,
  output logic signed [POSITION_WIDTH:0]   deriv_d
);

  localparam int PW = POSITION_WIDTH;
  localparam int IW = INTEGRAL_WIDTH;
  localparam int SW = ((IW > PW) ? IW : PW) + 1;
  localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

  logic signed [IW-1:0] error_sum;
  logic signed [PW-1:0] last_error;
  logic                 finished;

  logic signed [IW-1:0] es0, esum_new;
  logic signed [PW-1:0] le0;
  logic                 fin0;
  logic signed [SW-1:0] esum_full;
  logic                 esum_ovf;
  logic signed [PW:0]   deriv;
  kind_t                kind;

  // Restart clears the state before this tick uses it
  assign es0  = restart_c ? '0 : error_sum;
  assign le0  = restart_c ? '0 : last_error;
  assign fin0 = restart_c ? 1'b0 : finished;

  always_comb begin
    if (fin0) begin
      kind = KIND_DONE;
    end else if (mode == MODE_HALT) begin
      kind = KIND_HALT;
    end else if (near_c) begin
      kind = KIND_DONE;
    end else begin
      kind = KIND_PID;
    end
  end

  assign esum_full = SW'(es0) + SW'(err_c);
  assign esum_ovf  = (esum_full[SW-1:IW-1] != '0) && (esum_full[SW-1:IW-1] != '1);
  assign esum_new  = esum_ovf ? (esum_full[SW-1] ? IMIN : IMAX) : esum_full[IW-1:0];
  assign deriv     = (PW+1)'(err_c) - (PW+1)'(le0);

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= '0;
      finished   <= 1'b0;
    end else if (take) begin
      error_sum  <= (kind == KIND_PID) ? esum_new : es0;
      last_error <= (kind == KIND_PID) ? err_c : le0;
      finished   <= (kind == KIND_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      ctl_d.restart <= restart_c;
      ctl_d.kind    <= kind;
      err_d         <= err_c;
      esum_d        <= esum_new;
      deriv_d       <= deriv;
    end
  end

endmodule
`default_nettype wire

[rtl/core/pdsl_term.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdsl_term - one saturated gain times operand product
// Sign and magnitude split, two 32x32 partial products, recombine and
// saturate the magnitude at 2^60.
// ----------------------------------------------------------------------------
module pdsl_term import pdsl_pkg::*; #(
  parameter int OPERAND_WIDTH = INTEGRAL_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en_e,
  input  wire logic                       en_f,
  input  wire logic                       en_g,
  input  wire logic signed [GAIN_W-1:0]   gain,
  input  wire logic signed [OPERAND_WIDTH-1:0] operand,
  output logic        [TERM_W-1:0]        mag_g,
  output logic                            neg_g
);

  localparam logic [TERM_W-1:0] TERM_LIMIT = {1'b1, {(TERM_W-1){1'b0}}};

  logic signed [MAG_W-1:0] op_x;
  logic        [MAG_W-1:0] omag;
  logic        [GAIN_W-1:0] gmag;

  assign op_x = MAG_W'(operand);
  assign omag = op_x[MAG_W-1] ? (~op_x + 1'b1) : op_x;
  assign gmag = gain[GAIN_W-1] ? (~gain + 1'b1) : gain;

  // Stage E: magnitudes and product sign
  logic [MAG_W-1:0]  omag_e;
  logic [GAIN_W-1:0] gmag_e;
  logic              neg_e;

  always_ff @(posedge clk) begin
    if (en_e) begin
      omag_e <= omag;
      gmag_e <= gmag;
      neg_e  <= gain[GAIN_W-1] ^ operand[OPERAND_WIDTH-1];
    end
  end

  // Stage F: partial products
  logic [PROD_W-1:0] lo_f, hi_f;
  logic              neg_f;

  always_ff @(posedge clk) begin
    if (en_f) begin
      lo_f  <= gmag_e * omag_e[HALF_W-1:0];
      hi_f  <= gmag_e * omag_e[MAG_W-1:HALF_W];
      neg_f <= neg_e;
    end
  end

  logic [PROD_W+HALF_W-1:0] full;
  logic                     sat;

  assign full = {hi_f, {HALF_W{1'b0}}} + (PROD_W+HALF_W)'(lo_f);
  assign sat  = (|full[PROD_W+HALF_W-1:TERM_W]) ||
                (full[TERM_W-1] && (|full[TERM_W-2:0]));

  // Stage G: saturated magnitude
  always_ff @(posedge clk) begin
    if (en_g) begin
      mag_g <= sat ? TERM_LIMIT : full[TERM_W-1:0];
      neg_g <= neg_f;
    end
  end

endmodule
`default_nettype wire

[rtl/core/pdsl_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdsl_out - PID sum, Q1.15 conversion, slew limit and side mapping
// Holds the last power and the output register.
// ----------------------------------------------------------------------------
module pdsl_out import pdsl_pkg::*; #(
  parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en_h,
  input  wire logic               en_q,
  input  wire logic               en_o,
  input  wire logic               load_o,
  input  wire cfg_t               cfg,
  input  wire ctl_t               ctl_g,
  input  wire logic [TERM_W-1:0]  mag_p,
  input  wire logic               neg_p,
  input  wire logic [TERM_W-1:0]  mag_i,
  input  wire logic               neg_i,
  input  wire logic [TERM_W-1:0]  mag_d,
  input  wire logic               neg_d,
  output logic signed [POWER_W-1:0] left_power,
  output logic signed [POWER_W-1:0] right_power,
  output logic                    done_res
);

  localparam int GFB = GAIN_FRACTION_BITS;
  localparam int VW  = GFB + 2;
  localparam int QW  = POWER_W + 1;
  localparam int LW  = POWER_W + 2;
  localparam logic signed [SUM_W-1:0] UNITY     = SUM_W'(1) << GFB;
  localparam logic signed [SUM_W-1:0] NEG_UNITY = -UNITY;
  localparam logic signed [QW-1:0] QMAX = {2'b00, {(POWER_W-1){1'b1}}};
  localparam logic signed [POWER_W-1:0] PMAX = {1'b0, {(POWER_W-1){1'b1}}};
  localparam logic signed [POWER_W-1:0] PMIN = {1'b1, {(POWER_W-1){1'b0}}};

  function automatic logic signed [SUM_W-1:0] apply_sign(input logic neg,
                                                         input logic [TERM_W-1:0] m);
    logic signed [SUM_W-1:0] x;
    x = $signed(SUM_W'(m));
    return neg ? -x : x;
  endfunction

  // Stage H: PID sum
  logic signed [SUM_W-1:0] sum_h;
  ctl_t                    ctl_h;

  always_ff @(posedge clk) begin
    if (en_h) begin
      sum_h <= apply_sign(neg_p, mag_p) + apply_sign(neg_i, mag_i) +
               apply_sign(neg_d, mag_d);
      ctl_h <= ctl_g;
    end
  end

  // Clamp to plus or minus one, then rescale to Q1.15
  logic signed [SUM_W-1:0] v_c;
  logic signed [VW-1:0]    v_n;
  logic signed [QW-1:0]    r;

  assign v_c = (sum_h > UNITY) ? UNITY : ((sum_h < NEG_UNITY) ? NEG_UNITY : sum_h);
  assign v_n = v_c[VW-1:0];

  if (GFB >= POWER_FRAC) begin : g_shr
    logic signed [VW-1:0] v_sh;
    assign v_sh = v_n >>> (GFB - POWER_FRAC);
    assign r    = v_sh[QW-1:0];
  end else begin : g_shl
    assign r = QW'(v_n) <<< (POWER_FRAC - GFB);
  end

  // Stage Q: unlimited power
  logic signed [POWER_W-1:0] p_q;
  ctl_t                      ctl_q;

  always_ff @(posedge clk) begin
    if (en_q) begin
      p_q   <= (r > QMAX) ? PMAX : r[POWER_W-1:0];
      ctl_q <= ctl_h;
    end
  end

  logic signed [POWER_W-1:0] last_power;
  logic signed [POWER_W-1:0] base, p_s;
  logic signed [LW-1:0]      slew_x, up_x, dn_x, p_x, lim_x;
  logic                      slew_on, goal_pos;

  assign base     = ctl_q.restart ? '0 : last_power;
  assign slew_x   = $signed(LW'(cfg.slew_step));
  assign up_x     = LW'(base) + slew_x;
  assign dn_x     = LW'(base) - slew_x;
  assign p_x      = LW'(p_q);
  assign slew_on  = (cfg.slew_step != '0);
  assign lim_x    = (slew_on && (p_x > up_x)) ? up_x :
                    ((slew_on && (p_x < dn_x)) ? dn_x : p_x);
  // the limited value sits between p_q and base, so it fits
  assign p_s      = lim_x[POWER_W-1:0];
  assign goal_pos = (cfg.goal > 0);

  logic signed [POWER_W-1:0] left_next, right_next;
  logic                      done_next;

  always_comb begin
    left_next  = '0;
    right_next = '0;
    done_next  = 1'b0;
    case (ctl_q.kind)
      KIND_PID: begin
        left_next  = p_s;
        right_next = p_s;
        if (cfg.mode == MODE_TURN) begin
          right_next = (p_s == PMIN) ? PMAX : -p_s;
        end else if (cfg.mode == MODE_SWING) begin
          if (goal_pos) begin
            left_next = '0;
          end else begin
            right_next = '0;
          end
        end
      end
      KIND_DONE: done_next = 1'b1;
      default:   done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_power <= '0;
    end else if (load_o) begin
      if (ctl_q.kind == KIND_PID) begin
        last_power <= p_s;
      end else if (ctl_q.restart) begin
        last_power <= '0;
      end
    end
  end

  // Stage O: output register
  always_ff @(posedge clk) begin
    if (en_o) begin
      left_power  <= left_next;
      right_power <= right_next;
      done_res    <= done_next;
    end
  end

endmodule
`default_nettype wire

[rtl/core/pid_drive_with_slew_limit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pid_drive_with_slew_limit - PID drive controller with slew-rate limit
// Two-sided drive: position from wheels or heading, saturating PID, clamp to
// full scale, slew limit, turn and swing side mapping, settle detection.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | word
//  ---------+-----------+---------------------+---------------------------------
//  s_*      | in        | s_tvalid / s_tready | one control tick
//  m_*      | out       | m_tvalid / m_tready | left/right power and done flag
//  cfg_*    | in        | cfg_valid/cfg_ready | register index and write data
//
//  One word per cycle sustained while m_tready stays high; each tick passes
//  from s to m through the ten-stage pipeline (input, position, error, state,
//  magnitude, partial products, saturation, sum, Q1.15, slew-limited output).
//  Loop state lives in two feedback points: the integral stage and the slew
//  stage, so back-to-back ticks see their predecessor's state.
//  Reset clears configuration, loop state and all valid flags; no clearing pass.
//  A stalled m side holds its word; empty stages still fill, so s keeps taking
//  words until every stage is occupied.
//
module pid_drive_with_slew_limit import pdsl_pkg::*; #(
  parameter int POSITION_WIDTH     = POSITION_WIDTH_DEF,
  parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF,
  parameter int INTEGRAL_WIDTH     = INTEGRAL_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // restart[0], left_position[32:1], right_position[64:33], heading[96:65],
  // left_velocity[112:97], right_velocity[128:113], zero fill
  input  wire logic [S_TDATA_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // left_power[15:0], right_power[31:16], done_res[32], zero fill
  output logic [M_TDATA_W-1:0]        m_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW = POSITION_WIDTH;
  localparam int IW = INTEGRAL_WIDTH;

  // Pipeline stage numbers
  localparam int ST_A   = 1;
  localparam int ST_B   = 2;
  localparam int ST_C   = 3;
  localparam int ST_D   = 4;
  localparam int ST_E   = 5;
  localparam int ST_F   = 6;
  localparam int ST_G   = 7;
  localparam int ST_H   = 8;
  localparam int ST_Q   = 9;
  localparam int ST_O   = 10;
  localparam int STAGES = ST_O;

  // --------------------------------------------------------------------------
  // Configuration registers: always ready; to be written only while idle, not enforced here
  // --------------------------------------------------------------------------
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p      <= '0;
      cfg.gain_i      <= '0;
      cfg.gain_d      <= '0;
      cfg.slew_step   <= '0;
      cfg.settle_band <= '0;
      cfg.speed_limit <= '0;
      cfg.goal        <= '0;
      cfg.mode        <= MODE_DRIVE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GAIN_P:      cfg.gain_p      <= cfg_data;
        CFG_GAIN_I:      cfg.gain_i      <= cfg_data;
        CFG_GAIN_D:      cfg.gain_d      <= cfg_data;
        CFG_SLEW_STEP:   cfg.slew_step   <= cfg_data[SLEW_W-1:0];
        CFG_SETTLE_BAND: cfg.settle_band <= cfg_data[BAND_W-1:0];
        CFG_SPEED_LIMIT: cfg.speed_limit <= cfg_data[SPEED_W-1:0];
        CFG_GOAL:        cfg.goal        <= cfg_data;
        CFG_MODE:        cfg.mode        <= mode_t'(cfg_data[1:0]);
        default:         cfg.mode        <= cfg.mode;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage valids and enables: a stage loads when empty or when it drains
  // --------------------------------------------------------------------------
  logic [STAGES:1] v;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !v[STAGES] || m_tready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[ST_A]) begin
        v[ST_A] <= s_tvalid;
      end
      for (int k = ST_B; k <= STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_tready = en[ST_A];
  assign m_tvalid = v[ST_O];

  // --------------------------------------------------------------------------
  // Front: input register, position, error and settle check
  // --------------------------------------------------------------------------
  logic                 restart_c;
  logic signed [PW-1:0] err_c;
  logic                 near_c;

  pdsl_front #(
    .POSITION_WIDTH (PW)
  ) u_front (
    .clk            (clk),
    .en_a           (en[ST_A]),
    .en_b           (en[ST_B]),
    .en_c           (en[ST_C]),
    .cfg            (cfg),
    .restart        (s_tdata[0]),
    .left_position  (s_tdata[32:1]),
    .right_position (s_tdata[64:33]),
    .heading        (s_tdata[96:65]),
    .left_velocity  (s_tdata[112:97]),
    .right_velocity (s_tdata[128:113]),
    .restart_c      (restart_c),
    .err_c          (err_c),
    .near_c         (near_c)
  );

  // --------------------------------------------------------------------------
  // Loop state: advance integral and last error as a word enters stage D
  // --------------------------------------------------------------------------
  ctl_t                 ctl_d;
  logic signed [PW-1:0] err_d;
  logic signed [IW-1:0] esum_d;
  logic signed [PW:0]   deriv_d;

  pdsl_state #(
    .POSITION_WIDTH (PW),
    .INTEGRAL_WIDTH (IW)
  ) u_state (
    .clk       (clk),
    .rst       (rst),
    .en_d      (en[ST_D]),
    .take      (en[ST_D] && v[ST_C]),
    .mode      (cfg.mode),
    .restart_c (restart_c),
    .err_c     (err_c),
    .near_c    (near_c),
    .ctl_d     (ctl_d),
    .err_d     (err_d),
    .esum_d    (esum_d),
    .deriv_d   (deriv_d)
  );

  // Carry the control tag alongside the product stages
  ctl_t ctl_e, ctl_f, ctl_g;

  always_ff @(posedge clk) begin
    if (en[ST_E]) begin
      ctl_e <= ctl_d;
    end
    if (en[ST_F]) begin
      ctl_f <= ctl_e;
    end
    if (en[ST_G]) begin
      ctl_g <= ctl_f;
    end
  end

  // --------------------------------------------------------------------------
  // Three saturated products, P, I and D
  // --------------------------------------------------------------------------
  logic [TERM_W-1:0] mag_p, mag_i, mag_d;
  logic              neg_p, neg_i, neg_d;

  pdsl_term #(
    .OPERAND_WIDTH (PW)
  ) u_term_p (
    .clk     (clk),
    .en_e    (en[ST_E]),
    .en_f    (en[ST_F]),
    .en_g    (en[ST_G]),
    .gain    (cfg.gain_p),
    .operand (err_d),
    .mag_g   (mag_p),
    .neg_g   (neg_p)
  );

  pdsl_term #(
    .OPERAND_WIDTH (IW)
  ) u_term_i (
    .clk     (clk),
    .en_e    (en[ST_E]),
    .en_f    (en[ST_F]),
    .en_g    (en[ST_G]),
    .gain    (cfg.gain_i),
    .operand (esum_d),
    .mag_g   (mag_i),
    .neg_g   (neg_i)
  );

  pdsl_term #(
    .OPERAND_WIDTH (PW + 1)
  ) u_term_d (
    .clk     (clk),
    .en_e    (en[ST_E]),
    .en_f    (en[ST_F]),
    .en_g    (en[ST_G]),
    .gain    (cfg.gain_d),
    .operand (deriv_d),
    .mag_g   (mag_d),
    .neg_g   (neg_d)
  );

  // --------------------------------------------------------------------------
  // Sum, Q1.15, slew limit and output register; last power moves on load
  // --------------------------------------------------------------------------
  logic signed [POWER_W-1:0] left_power, right_power;
  logic                      done_res;

  pdsl_out #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .en_h        (en[ST_H]),
    .en_q        (en[ST_Q]),
    .en_o        (en[ST_O]),
    .load_o      (en[ST_O] && v[ST_Q]),
    .cfg         (cfg),
    .ctl_g       (ctl_g),
    .mag_p       (mag_p),
    .neg_p       (neg_p),
    .mag_i       (mag_i),
    .neg_i       (neg_i),
    .mag_d       (mag_d),
    .neg_d       (neg_d),
    .left_power  (left_power),
    .right_power (right_power),
    .done_res    (done_res)
  );

  assign m_tdata = {{(M_TDATA_W - 2*POWER_W - 1){1'b0}}, done_res, right_power, left_power};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A finished tick always commands zero power on both sides
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2*POWER_W]) |-> (m_tdata[2*POWER_W-1:0] == '0))
    else $error("done word carries nonzero power");

  // With the output register empty nothing upstream may block input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // A halted tick in flight means the halt mode is still configured
  a_halt_mode: assert property (@(posedge clk) disable iff (rst)
    (v[ST_G] && (ctl_g.kind == KIND_HALT)) |-> (cfg.mode == MODE_HALT))
    else $error("halt tag without halt mode");

  // The stage D tag never claims a PID tick while the halt mode is set
  a_pid_mode: assert property (@(posedge clk) disable iff (rst)
    (v[ST_D] && (ctl_d.kind == KIND_PID)) |-> (cfg.mode != MODE_HALT))
    else $error("PID tag in halt mode");

endmodule
`default_nettype wire

[sim/tb_pid_drive_with_slew_limit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_drive_with_slew_limit - self-checking bench for the PID drive block
// Drives control ticks with random gaps, pulls power words with random stalls,
// and checks every word against a cycle-free model of the control law.
// The model covers position selection, integral saturation, term capping,
// Q1.15 conversion and slew limiting. Directed ticks come first, then random
// maneuvers that converge on the goal under many register settings.
// ----------------------------------------------------------------------------
module tb_pid_drive_with_slew_limit;
  import pdsl_pkg::*;

  // Control tick as it travels on s_tdata, highest field first
  typedef struct packed {
    logic signed [VEL_W-1:0]   right_vel;
    logic signed [VEL_W-1:0]   left_vel;
    logic signed [FIELD_W-1:0] heading;
    logic signed [FIELD_W-1:0] right_pos;
    logic signed [FIELD_W-1:0] left_pos;
    logic                      restart;
  } tick_t;

  // One drive word expected on m_tdata
  typedef struct packed {
    logic signed [POWER_W-1:0] left;
    logic signed [POWER_W-1:0] right;
    logic                      done;
  } drive_word_t;

  localparam logic signed [31:0] POS_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN    = 32'sh8000_0000;
  localparam logic signed [31:0] UNITY_GAIN = 32'sh0001_0000;

  // Arithmetic limits of the control law
  localparam longint ERR_MAX   = (64'sd1 <<< (POSITION_WIDTH_DEF - 1)) - 1;
  localparam longint ERR_MIN   = -ERR_MAX - 1;
  localparam longint INTEG_MAX = (64'sd1 <<< (INTEGRAL_WIDTH_DEF - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;
  localparam longint TERM_CAP  = 64'sd1 <<< 60;
  localparam longint UNITY     = 64'sd1 <<< GAIN_FRACTION_BITS_DEF;
  localparam int     Q_SHIFT   = GAIN_FRACTION_BITS_DEF - POWER_FRAC;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_tvalid;
  logic                   s_tready;
  // restart[0], left_position[32:1], right_position[64:33], heading[96:65],
  // left_velocity[112:97], right_velocity[128:113], zero fill
  logic [S_TDATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // left_power[15:0], right_power[31:16], done_res[32], zero fill
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Register shadow and loop state of the model
  cfg_t   shadow;
  longint integral_acc;
  longint prev_error;
  longint prev_power;
  bit     maneuver_done;

  drive_word_t pending_drive[$];

  bit steady_flow;  // when set, neither side idles
  int error_count;
  int ticks_sent;
  int words_checked;
  int settled_words;
  int settings_loaded;

  pid_drive_with_slew_limit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the control law
  // --------------------------------------------------------------------------
  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint rand_span(input int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  // gain * operand, magnitude capped at 2^60
  function automatic longint capped_term(input logic signed [31:0] gain, input longint opnd);
    logic signed [127:0] wide_gain;
    logic signed [127:0] wide_opnd;
    logic signed [127:0] prod;
    wide_gain = gain;
    wide_opnd = opnd;
    prod = wide_gain * wide_opnd;
    if (prod > TERM_CAP) return TERM_CAP;
    if (prod < -TERM_CAP) return -TERM_CAP;
    return prod[63:0];
  endfunction

  function automatic drive_word_t predict_drive(input tick_t t);
    drive_word_t w;
    longint pos, err, deriv, sum, p, lim, l_out, r_out;
    w = '0;
    if (t.restart) begin
      integral_acc  = 0;
      prev_error    = 0;
      prev_power    = 0;
      maneuver_done = 1'b0;
    end
    // A finished maneuver answers done and leaves all state alone
    if (maneuver_done) begin
      w.done = 1'b1;
      return w;
    end
    if (shadow.mode == MODE_HALT) return w;

    // Drive mode uses the floored wheel average, turn and swing the heading
    if (shadow.mode == MODE_DRIVE)
      pos = (longint'(t.left_pos) + longint'(t.right_pos)) >>> 1;
    else
      pos = longint'(t.heading);
    err = longint'(shadow.goal) - pos;
    if (err > ERR_MAX) err = ERR_MAX;
    if (err < ERR_MIN) err = ERR_MIN;

    // Settled: error in band and both sides slow; -32768 is never slow
    if (magnitude(err) <= longint'(shadow.settle_band) &&
        magnitude(t.left_vel) <= longint'(shadow.speed_limit) &&
        magnitude(t.right_vel) <= longint'(shadow.speed_limit)) begin
      maneuver_done = 1'b1;
      w.done = 1'b1;
      return w;
    end

    integral_acc = integral_acc + err;
    if (integral_acc > INTEG_MAX) integral_acc = INTEG_MAX;
    if (integral_acc < INTEG_MIN) integral_acc = INTEG_MIN;
    deriv = err - prev_error;
    prev_error = err;

    sum = capped_term(shadow.gain_p, err) + capped_term(shadow.gain_i, integral_acc) +
          capped_term(shadow.gain_d, deriv);
    if (sum > UNITY) sum = UNITY;
    if (sum < -UNITY) sum = -UNITY;
    p = ((sum + UNITY) >>> Q_SHIFT) - 32768;
    if (p > 32767) p = 32767;

    lim = longint'(shadow.slew_step);
    if (lim != 0) begin
      if (p > prev_power + lim) p = prev_power + lim;
      if (p < prev_power - lim) p = prev_power - lim;
    end
    prev_power = p;

    l_out = p;
    r_out = p;
    if (shadow.mode == MODE_TURN) begin
      r_out = (p == -32768) ? 32767 : -p;
    end else if (shadow.mode == MODE_SWING) begin
      if (shadow.goal > 0) l_out = 0;
      else r_out = 0;
    end
    w.left  = l_out[15:0];
    w.right = r_out[15:0];
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers for building ticks and settings
  // --------------------------------------------------------------------------
  function automatic tick_t tick_of(input logic restart, input logic signed [31:0] lp,
                                    input logic signed [31:0] rp, input logic signed [31:0] hd,
                                    input logic signed [15:0] lv, input logic signed [15:0] rv);
    tick_t t;
    t.restart   = restart;
    t.left_pos  = lp;
    t.right_pos = rp;
    t.heading   = hd;
    t.left_vel  = lv;
    t.right_vel = rv;
    return t;
  endfunction

  function automatic cfg_t settings_of(input logic signed [31:0] gp, input logic signed [31:0] gi,
                                       input logic signed [31:0] gd, input logic [15:0] slew,
                                       input logic [30:0] band, input logic [14:0] speed,
                                       input logic signed [31:0] goal, input mode_t mode);
    cfg_t c;
    c.gain_p      = gp;
    c.gain_i      = gi;
    c.gain_d      = gd;
    c.slew_step   = slew;
    c.settle_band = band;
    c.speed_limit = speed;
    c.goal        = goal;
    c.mode        = mode;
    return c;
  endfunction

  // Two fixed corners, then mostly moderate gains with the odd extreme
  function automatic cfg_t draw_settings(input int phase);
    cfg_t c;
    if (phase == 0) begin
      c = settings_of(POS_MAX, POS_MIN, POS_MAX, 16'hFFFF, 31'h7FFF_FFFF, 15'h7FFF, POS_MAX,
                      MODE_SWING);
    end else if (phase == 1) begin
      c = settings_of(POS_MIN, POS_MAX, POS_MIN, 16'd0, 31'd0, 15'd0, POS_MIN, MODE_TURN);
    end else begin
      c.gain_p = ($urandom_range(0, 7) == 0) ? $urandom : rand_span(1 << 18);
      c.gain_i = ($urandom_range(0, 7) == 0) ? $urandom : rand_span(1 << 12);
      c.gain_d = ($urandom_range(0, 7) == 0) ? $urandom : rand_span(1 << 17);
      case ($urandom_range(0, 3))
        0:       c.slew_step = 16'd0;
        1:       c.slew_step = 16'hFFFF;
        default: c.slew_step = $urandom_range(1, 4000);
      endcase
      c.settle_band = ($urandom_range(0, 4) == 0) ? 31'h7FFF_FFFF : $urandom_range(0, 2000);
      c.speed_limit = ($urandom_range(0, 4) == 0) ? 15'h7FFF : $urandom_range(0, 600);
      c.goal = ($urandom_range(0, 5) == 0) ? $urandom : rand_span(1 << 20);
      c.mode = ($urandom_range(0, 9) == 0) ? MODE_HALT : mode_t'($urandom_range(0, 2));
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR @%0t word %0d %s: got %0d, expected %0d", $realtime, words_checked, what,
             got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus plumbing; every task is entered and left just after a falling edge
  // --------------------------------------------------------------------------
  task automatic send_tick(input tick_t t);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    // Drop valid only when a gap is taken, so back-to-back words keep it high
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {7'd0, t};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_drive.push_back(predict_drive(t));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Hold off until every word is back, then let the pipeline empty out
  task automatic settle_pipeline();
    int waited;
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending_drive.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (12) @(negedge clk);
  endtask

  // Write all eight registers back to back; junk above each field's width
  task automatic load_settings(input cfg_t c);
    cfg_reg_t    r;
    logic [31:0] word;
    int          i;
    cfg_valid <= 1'b1;
    for (i = 0; i < 8; i++) begin
      r = cfg_reg_t'(i);
      word = $urandom;
      case (r)
        CFG_GAIN_P:      word = c.gain_p;
        CFG_GAIN_I:      word = c.gain_i;
        CFG_GAIN_D:      word = c.gain_d;
        CFG_SLEW_STEP:   word[15:0] = c.slew_step;
        CFG_SETTLE_BAND: word[30:0] = c.settle_band;
        CFG_SPEED_LIMIT: word[14:0] = c.speed_limit;
        CFG_GOAL:        word = c.goal;
        CFG_MODE:        word[1:0] = c.mode;
        default:         word = $urandom;
      endcase
      cfg_index <= r;
      cfg_data  <= word;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    shadow = c;
    settings_loaded++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Position and velocity extremes, error saturation, floored drive average
  task automatic test_field_extremes();
    settle_pipeline();
    load_settings(settings_of(POS_MAX, 0, 0, 16'd0, 31'd0, 15'd0, POS_MAX, MODE_DRIVE));
    send_tick(tick_of(1'b1, POS_MIN, POS_MIN, 0, 0, 0));
    send_tick(tick_of(1'b0, POS_MAX, POS_MAX, POS_MIN, 16'sh7FFF, 16'sh8000));
    send_tick(tick_of(1'b0, -3, 0, POS_MAX, 16'sh8000, 16'sh7FFF));
    send_tick(tick_of(1'b0, 3, -1, 0, -1, 1));
    settle_pipeline();
    load_settings(settings_of(POS_MIN, POS_MAX, POS_MIN, 16'hFFFF, 31'd0, 15'd0, POS_MAX,
                              MODE_DRIVE));
    send_tick(tick_of(1'b0, POS_MIN, POS_MIN, 0, 1, 1));
    send_tick(tick_of(1'b0, POS_MIN, POS_MAX, 0, 1, 1));
  endtask

  // Turn negation including full negative scale, swing on both goal signs
  task automatic test_turn_and_swing();
    settle_pipeline();
    load_settings(settings_of(POS_MIN, 0, 0, 16'd0, 31'd0, 15'd0, POS_MAX, MODE_TURN));
    send_tick(tick_of(1'b1, 0, 0, POS_MIN, 0, 0));
    send_tick(tick_of(1'b0, 0, 0, POS_MAX, 5, 5));
    send_tick(tick_of(1'b0, 0, 0, 32'sh7FFF_FFF0, 5, 5));
    settle_pipeline();
    load_settings(settings_of(32'sd16, 0, 0, 16'd0, 31'd0, 15'd0, 1000, MODE_SWING));
    send_tick(tick_of(1'b1, 7, 7, 0, 9, 9));
    send_tick(tick_of(1'b0, 7, 7, 1500, 9, 9));
    settle_pipeline();
    load_settings(settings_of(32'sd16, 0, 0, 16'd0, 31'd0, 15'd0, 0, MODE_SWING));
    send_tick(tick_of(1'b1, 0, 0, -300, 9, 9));
    settle_pipeline();
    load_settings(settings_of(32'sd16, 0, 0, 16'd0, 31'd0, 15'd0, -70000, MODE_SWING));
    send_tick(tick_of(1'b1, 0, 0, 0, 9, 9));
  endtask

  // Ramp up under a small step, reverse, then the widest step
  task automatic test_slew_limit();
    settle_pipeline();
    load_settings(settings_of(UNITY_GAIN, 0, 0, 16'd1000, 31'd0, 15'd0, 0, MODE_DRIVE));
    send_tick(tick_of(1'b1, -30000, -30000, 0, 50, 50));
    send_tick(tick_of(1'b0, -30000, -30000, 0, 50, 50));
    send_tick(tick_of(1'b0, -30000, -30000, 0, 50, 50));
    send_tick(tick_of(1'b0, 30000, 30000, 0, 50, 50));
    settle_pipeline();
    load_settings(settings_of(UNITY_GAIN, 0, 0, 16'hFFFF, 31'd0, 15'd0, 0, MODE_DRIVE));
    send_tick(tick_of(1'b0, 30000, 30000, 0, 50, 50));
  endtask

  // Full negative scale velocity never counts as stopped; done sticks until restart
  task automatic test_settle_and_restart();
    settle_pipeline();
    load_settings(settings_of(UNITY_GAIN, 0, 0, 16'd0, 31'd100, 15'h7FFF, 500, MODE_DRIVE));
    send_tick(tick_of(1'b1, 0, 0, 0, 16'sh8000, 0));
    send_tick(tick_of(1'b0, 450, 451, 0, 16'sh8000, 12));
    send_tick(tick_of(1'b0, 450, 451, 0, 16'sh7FFF, -32767));
    send_tick(tick_of(1'b0, 0, 0, 0, 0, 0));
    send_tick(tick_of(1'b1, 0, 0, 0, 0, 0));
    send_tick(tick_of(1'b0, 599, 601, 0, 0, 0));
  endtask

  // Halt mode answers zero power and no done, restart or not
  task automatic test_halt_mode();
    settle_pipeline();
    load_settings(settings_of(UNITY_GAIN, UNITY_GAIN, UNITY_GAIN, 16'd0, 31'h7FFF_FFFF,
                              15'h7FFF, 0, MODE_HALT));
    send_tick(tick_of(1'b1, 0, 0, 0, 0, 0));
    send_tick(tick_of(1'b0, 100, -100, 5, 1, 1));
  endtask

  // Converging maneuvers with random content, some noise ticks and restarts
  task automatic test_random_maneuvers();
    cfg_t   c;
    tick_t  t;
    longint offset, lv, rv, aim;
    int     phase, k, sent, len;
    for (phase = 0; phase < 8; phase++) begin
      c = draw_settings(phase);
      settle_pipeline();
      load_settings(c);
      steady_flow = (phase % 3 == 2);
      sent = 0;
      while (sent < 50) begin
        offset = ($urandom_range(0, 5) == 0) ? longint'($signed($urandom)) : rand_span(1 << 16);
        lv = rand_span(3000);
        rv = rand_span(3000);
        len = $urandom_range(4, 18);
        for (k = 0; k < len && sent < 50; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            t.restart   = $urandom_range(0, 1);
            t.left_pos  = $urandom;
            t.right_pos = $urandom;
            t.heading   = $urandom;
            t.left_vel  = $urandom;
            t.right_vel = $urandom;
          end else begin
            aim = longint'(c.goal) - offset;
            t.restart   = (k == 0) || ($urandom_range(0, 29) == 0);
            t.left_pos  = aim + rand_span(3);
            t.right_pos = aim - rand_span(3);
            t.heading   = aim + rand_span(1);
            t.left_vel  = lv;
            t.right_vel = rv;
          end
          send_tick(t);
          sent++;
          // Close in on the goal and slow down
          offset = offset * longint'($urandom_range(30, 80)) / 100;
          lv = lv * 3 / 4;
          rv = rv * 3 / 4;
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, compare each accepted word
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_words
    drive_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_drive.size() == 0) begin
        report_mismatch("word with nothing pending", longint'(m_tdata), 0);
      end else begin
        want = pending_drive.pop_front();
        if (m_tdata[15:0] !== want.left)
          report_mismatch("left_power", longint'($signed(m_tdata[15:0])), want.left);
        if (m_tdata[31:16] !== want.right)
          report_mismatch("right_power", longint'($signed(m_tdata[31:16])), want.right);
        if (m_tdata[32] !== want.done)
          report_mismatch("done_res", longint'(m_tdata[32]), want.done);
        if (want.done) settled_words++;
        words_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    shadow        = '0;
    integral_acc  = 0;
    prev_error    = 0;
    prev_power    = 0;
    maneuver_done = 1'b0;
    steady_flow   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_turn_and_swing();
    test_slew_limit();
    test_settle_and_restart();
    test_halt_mode();
    test_random_maneuvers();

    settle_pipeline();
    if (pending_drive.size() != 0)
      report_mismatch("words never delivered", pending_drive.size(), 0);
    $display("Ran %0d control ticks, %0d words checked (%0d settled)", ticks_sent,
             words_checked, settled_words);
    $display("over %0d register settings in drive, turn, swing and halt modes",
             settings_loaded);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: the slowest correct run takes well under a tenth of this
  initial begin : watchdog
    #400000;
    $display("Timeout: handshakes stopped moving");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
